[rtl/dps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants for the drive power and homing sequencer.
// ----------------------------------------------------------------------------
package dps_pkg;

    typedef enum logic [1:0] {
        REQ_DISABLE  = 2'd0,
        REQ_ENABLE   = 2'd1,
        REQ_HOME     = 2'd2,
        REQ_SET_MODE = 2'd3
    } t_req;

    typedef logic [4:0] t_code;

    localparam t_code CODE_DONE          = 5'd0;
    localparam t_code CODE_WAIT          = 5'd1;
    localparam t_code CODE_SHUTDOWN      = 5'd2;
    localparam t_code CODE_SWITCH_ON     = 5'd3;
    localparam t_code CODE_ENABLE_OP     = 5'd4;
    localparam t_code CODE_SETTLE        = 5'd5;
    localparam t_code CODE_DISVOLT_QS    = 5'd6;
    localparam t_code CODE_DISVOLT_FAULT = 5'd7;
    localparam t_code CODE_FAULT_RESET   = 5'd8;
    localparam t_code CODE_UNKNOWN       = 5'd9;
    localparam t_code CODE_HOME_NEED_EN  = 5'd10;
    localparam t_code CODE_HOME_MODE_WR  = 5'd11;
    localparam t_code CODE_HOME_CLEAR    = 5'd12;
    localparam t_code CODE_HOME_START    = 5'd13;
    localparam t_code CODE_HOME_BUSY     = 5'd14;
    localparam t_code CODE_HOME_ERROR    = 5'd15;
    localparam t_code CODE_MODE_PENDING  = 5'd16;
    localparam t_code CODE_MAX           = CODE_MODE_PENDING;

    // status word masks and decoded states
    localparam logic [15:0] SW_MASK_4F      = 16'h004F;
    localparam logic [15:0] SW_MASK_6F      = 16'h006F;
    localparam logic [15:0] SW_NOT_READY    = 16'h0000;
    localparam logic [15:0] SW_SW_ON_DIS    = 16'h0040;
    localparam logic [15:0] SW_READY        = 16'h0021;
    localparam logic [15:0] SW_SWITCHED_ON  = 16'h0023;
    localparam logic [15:0] SW_OP_ENABLED   = 16'h0027;
    localparam logic [15:0] SW_QUICK_STOP   = 16'h0007;
    localparam logic [15:0] SW_FAULT_REACT  = 16'h000F;
    localparam logic [15:0] SW_FAULT        = 16'h0008;
    localparam logic [15:0] SW_TARGET_BIT   = 16'h0400;
    localparam logic [15:0] SW_HOME_MASK    = 16'h3400;
    localparam logic [15:0] SW_HOME_OK      = 16'h1400;

    // control words
    localparam logic [15:0] CW_SHUTDOWN     = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON    = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP    = 16'h000F;
    localparam logic [15:0] CW_HOME_START   = 16'h001F;
    localparam logic [15:0] CW_DISABLE_VOLT = 16'h0000;
    localparam logic [15:0] CW_FAULT_RESET  = 16'h0080;
    localparam logic [15:0] CW_HOME_RUN_BIT = 16'h0010;

    // operating modes
    localparam logic [7:0] OPM_HOMING = 8'h06;
    localparam logic [7:0] OPM_CSP    = 8'h08;
    localparam logic [7:0] OPM_CSV    = 8'h09;
    localparam logic [7:0] OPM_CST    = 8'h10;

    localparam logic [7:0] SETTLE_RESET = 8'd20;

    typedef struct packed {
        logic               ctrl_write;
        logic [15:0]        ctrl_value;
        logic               opmode_write;
        logic [7:0]         op_mode;
        logic               pos_write;
        logic signed [31:0] target_pos;
        logic               vel_zero;
        logic               cur_zero;
        t_code              code;
    } t_result;

endpackage

[rtl/dps_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_if
// Valid/ready channels of the drive power and homing sequencer.
// ----------------------------------------------------------------------------
interface dps_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [15:0]        drive_status;
    logic [7:0]         display_mode;
    logic signed [31:0] actual_pos;
    logic [7:0]         requested_mode;

    modport source (output valid, mode, drive_status, display_mode, actual_pos,
                    requested_mode, input ready);
    modport sink   (input valid, mode, drive_status, display_mode, actual_pos,
                    requested_mode, output ready);
endinterface

interface dps_res_if;
    logic               valid;
    logic               ready;
    logic               ctrl_write;
    logic [15:0]        ctrl_value;
    logic               opmode_write;
    logic [7:0]         op_mode;
    logic               pos_write;
    logic signed [31:0] target_pos;
    logic               vel_zero;
    logic               cur_zero;
    logic [4:0]         code;

    modport source (output valid, ctrl_write, ctrl_value, opmode_write, op_mode,
                    pos_write, target_pos, vel_zero, cur_zero, code, input ready);
    modport sink   (input valid, ctrl_write, ctrl_value, opmode_write, op_mode,
                    pos_write, target_pos, vel_zero, cur_zero, code, output ready);
endinterface

interface dps_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/drive_power_homing_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_power_homing_sequencer
// Master-side drive power and homing sequencer: decodes the status word of
// each poll and chooses control word, mode write or target seeding.
// ----------------------------------------------------------------------------
// a request passes through the input register and then the result register
// throughput: one request per cycle while results are taken, set by the input and result registers
// a stalled result holds the pipe; one more request can fill an empty input register
// reset: settle_cycles returns to 20, settle count and homing control word to 0,
// both pipeline stages empty; the config write channel is always ready
module drive_power_homing_sequencer (
    input  logic i_clk,
    input  logic i_rst_n,
    dps_req_if.sink   i_req,
    dps_res_if.source o_res,
    dps_cfg_if.sink   i_cfg
);

    // input register
    logic               r_in_valid;
    dps_pkg::t_req      r_mode;
    logic [15:0]        r_drive_status;
    logic [7:0]         r_display_mode;
    logic signed [31:0] r_actual_pos;
    logic [7:0]         r_requested_mode;

    // result register
    logic               r_out_valid;
    dps_pkg::t_result   r_res;
    dps_pkg::t_result   n_res;

    // sequencer state
    logic [7:0]         r_settle_cycles;
    logic [7:0]         r_settle_count;
    logic [7:0]         n_settle_count;
    logic [15:0]        r_homing_control;
    logic [15:0]        n_homing_control;

    logic               advance;
    logic               in_ready;
    logic               fire;

    logic [15:0]        sw_m4;
    logic [15:0]        sw_m6;
    logic [7:0]         settle_dec;
    logic               home_running;
    logic               home_attained;

    assign advance  = !r_out_valid || o_res.ready;
    assign in_ready = !r_in_valid || advance;
    assign fire     = r_in_valid && advance;

    assign i_req.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    assign sw_m4         = r_drive_status & dps_pkg::SW_MASK_4F;
    assign sw_m6         = r_drive_status & dps_pkg::SW_MASK_6F;
    assign settle_dec    = (r_settle_count != 8'd0) ? r_settle_count - 8'd1 : 8'd0;
    assign home_running  = (r_homing_control & dps_pkg::CW_HOME_RUN_BIT) != 16'd0;
    assign home_attained = (r_drive_status & dps_pkg::SW_TARGET_BIT) != 16'd0;

    always_comb begin
        n_res            = '0;
        n_settle_count   = r_settle_count;
        n_homing_control = r_homing_control;
        case (r_mode)
            dps_pkg::REQ_DISABLE, dps_pkg::REQ_ENABLE: begin
                if (sw_m4 == dps_pkg::SW_NOT_READY) begin
                    n_res.code = dps_pkg::CODE_WAIT;
                end else if (sw_m4 == dps_pkg::SW_SW_ON_DIS) begin
                    n_res.ctrl_write = 1'b1;
                    n_res.ctrl_value = dps_pkg::CW_SHUTDOWN;
                    n_res.code       = dps_pkg::CODE_SHUTDOWN;
                end else if (sw_m6 == dps_pkg::SW_READY) begin
                    n_res.ctrl_write = 1'b1;
                    n_res.ctrl_value = dps_pkg::CW_SWITCH_ON;
                    n_res.code       = dps_pkg::CODE_SWITCH_ON;
                end else if (sw_m6 == dps_pkg::SW_SWITCHED_ON) begin
                    if (r_mode == dps_pkg::REQ_ENABLE) begin
                        n_res.ctrl_write = 1'b1;
                        n_res.ctrl_value = dps_pkg::CW_ENABLE_OP;
                        n_settle_count   = r_settle_cycles;
                        // seed the setpoints that the displayed mode follows, or all of them for other modes
                        if (r_display_mode == dps_pkg::OPM_CSP) begin
                            n_res.pos_write  = 1'b1;
                            n_res.target_pos = r_actual_pos;
                        end else if (r_display_mode == dps_pkg::OPM_CSV) begin
                            n_res.vel_zero = 1'b1;
                        end else if (r_display_mode == dps_pkg::OPM_CST) begin
                            n_res.cur_zero = 1'b1;
                        end else begin
                            n_res.pos_write  = 1'b1;
                            n_res.target_pos = r_actual_pos;
                            n_res.vel_zero   = 1'b1;
                            n_res.cur_zero   = 1'b1;
                        end
                        n_res.code = dps_pkg::CODE_ENABLE_OP;
                    end else begin
                        n_res.code = dps_pkg::CODE_DONE;
                    end
                end else if (sw_m6 == dps_pkg::SW_OP_ENABLED) begin
                    if (r_mode == dps_pkg::REQ_ENABLE) begin
                        n_settle_count = settle_dec;
                        n_res.code = (settle_dec != 8'd0) ? dps_pkg::CODE_SETTLE
                                                          : dps_pkg::CODE_DONE;
                    end else begin
                        n_res.ctrl_write = 1'b1;
                        n_res.ctrl_value = dps_pkg::CW_SHUTDOWN;
                        n_res.code       = dps_pkg::CODE_SHUTDOWN;
                    end
                end else if (sw_m6 == dps_pkg::SW_QUICK_STOP) begin
                    n_res.ctrl_write = 1'b1;
                    n_res.ctrl_value = dps_pkg::CW_DISABLE_VOLT;
                    n_res.code       = dps_pkg::CODE_DISVOLT_QS;
                end else if (sw_m4 == dps_pkg::SW_FAULT_REACT) begin
                    n_res.ctrl_write = 1'b1;
                    n_res.ctrl_value = dps_pkg::CW_DISABLE_VOLT;
                    n_res.code       = dps_pkg::CODE_DISVOLT_FAULT;
                end else if (sw_m4 == dps_pkg::SW_FAULT) begin
                    n_res.ctrl_write = 1'b1;
                    n_res.ctrl_value = dps_pkg::CW_FAULT_RESET;
                    n_res.code       = dps_pkg::CODE_FAULT_RESET;
                end else begin
                    n_res.code = dps_pkg::CODE_UNKNOWN;
                end
            end
            dps_pkg::REQ_HOME: begin
                if (sw_m6 != dps_pkg::SW_OP_ENABLED) begin
                    n_res.code = dps_pkg::CODE_HOME_NEED_EN;
                end else if (r_display_mode != dps_pkg::OPM_HOMING) begin
                    n_res.opmode_write = 1'b1;
                    n_res.op_mode      = dps_pkg::OPM_HOMING;
                    n_res.code         = dps_pkg::CODE_HOME_MODE_WR;
                end else if (!home_running && home_attained) begin
                    // drop the start bit so a fresh rising edge can follow
                    n_res.ctrl_write = 1'b1;
                    n_res.ctrl_value = dps_pkg::CW_ENABLE_OP;
                    n_homing_control = dps_pkg::CW_ENABLE_OP;
                    n_res.code       = dps_pkg::CODE_HOME_CLEAR;
                end else if (!home_running) begin
                    n_res.ctrl_write = 1'b1;
                    n_res.ctrl_value = dps_pkg::CW_HOME_START;
                    n_homing_control = dps_pkg::CW_HOME_START;
                    n_res.code       = dps_pkg::CODE_HOME_START;
                end else if (!home_attained) begin
                    n_res.code = dps_pkg::CODE_HOME_BUSY;
                end else if ((r_drive_status & dps_pkg::SW_HOME_MASK) == dps_pkg::SW_HOME_OK) begin
                    n_res.code = dps_pkg::CODE_DONE;
                end else begin
                    n_res.code = dps_pkg::CODE_HOME_ERROR;
                end
            end
            dps_pkg::REQ_SET_MODE: begin
                n_res.opmode_write = 1'b1;
                n_res.op_mode      = r_requested_mode;
                n_res.code = (r_requested_mode == r_display_mode) ? dps_pkg::CODE_DONE
                                                                  : dps_pkg::CODE_MODE_PENDING;
            end
            default: begin
                n_res.code = dps_pkg::CODE_UNKNOWN;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_settle_cycles  <= dps_pkg::SETTLE_RESET;
            r_settle_count   <= 8'd0;
            r_homing_control <= 16'd0;
        end else begin
            if (i_cfg.valid) begin
                r_settle_cycles <= i_cfg.data;
            end
            if (in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_settle_count   <= n_settle_count;
                r_homing_control <= n_homing_control;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && in_ready) begin
            r_mode           <= dps_pkg::t_req'(i_req.mode);
            r_drive_status   <= i_req.drive_status;
            r_display_mode   <= i_req.display_mode;
            r_actual_pos     <= i_req.actual_pos;
            r_requested_mode <= i_req.requested_mode;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.ctrl_write   = r_res.ctrl_write;
    assign o_res.ctrl_value   = r_res.ctrl_value;
    assign o_res.opmode_write = r_res.opmode_write;
    assign o_res.op_mode      = r_res.op_mode;
    assign o_res.pos_write    = r_res.pos_write;
    assign o_res.target_pos   = r_res.target_pos;
    assign o_res.vel_zero     = r_res.vel_zero;
    assign o_res.cur_zero     = r_res.cur_zero;
    assign o_res.code         = r_res.code;

endmodule

[rtl/dps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_checker
// Port-level checks on the result channel of the sequencer.
// ----------------------------------------------------------------------------
module dps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic               i_ctrl_write,
    input logic [15:0]        i_ctrl_value,
    input logic               i_opmode_write,
    input logic [7:0]         i_op_mode,
    input logic               i_pos_write,
    input logic signed [31:0] i_target_pos,
    input logic [4:0]         i_code
);

    // a stalled result transaction keeps its code, control word and target position
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_code) && $stable(i_ctrl_value)
            && $stable(i_target_pos))
        else $error("result changed while stalled");

    a_cw_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ctrl_write |-> i_ctrl_value == 16'd0)
        else $error("control word set without write flag");

    a_pos_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_pos_write |-> i_target_pos == 32'sd0 && (i_opmode_write ||
            i_op_mode == 8'd0))
        else $error("position or mode set without write flag");

    // result codes stay within CODE_MAX and no result writes both mode and control word
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_code <= dps_pkg::CODE_MAX && !(i_opmode_write && i_ctrl_write))
        else $error("bad result code or conflicting writes");

endmodule

bind drive_power_homing_sequencer dps_checker u_dps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_ctrl_write   (o_res.ctrl_write),
    .i_ctrl_value   (o_res.ctrl_value),
    .i_opmode_write (o_res.opmode_write),
    .i_op_mode      (o_res.op_mode),
    .i_pos_write    (o_res.pos_write),
    .i_target_pos   (o_res.target_pos),
    .i_code         (o_res.code)
);
